// File: hw/rtl/rarsf_pkg.sv
// shared types and constants for the range-add / range-sum fenwick store
// no dependencies
package rarsf_pkg;

	localparam int unsigned MAX_POSITIONS_DEF = 1024;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned POS_W = 11;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned SUM_W = 64;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic kind;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] range_sum;
		logic bad_range;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic first;
		logic upd;
		logic mul;
		logic acc;
		logic second;
		logic walk;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic bad;
		logic query;
		logic walk_live;
	} stat_t;

endpackage

// File: hw/rtl/range_add_range_sum_fenwick.sv
// a walk takes at most floor(log2 of the size in use) + 1 steps, each a read then an update
// one item at a time: after the done state the block returns to idle before it takes the next
// after reset a clear pass over all MAX_POSITIONS+1 tree words holds busy high
// results are a one-cycle done strobe; the receiver cannot stall
// top level: ties controller and datapath, depends on rarsf_pkg, rarsf_ctrl, rarsf_dp
module range_add_range_sum_fenwick import rarsf_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	output logic              busy,
	output logic              done,
	output rsp_t              res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	cmd_t cmd;
	stat_t stat;

	// size register takes a beat at any time
	assign cfg_ready = 1'b1;

	rarsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	rarsf_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

endmodule

// File: hw/rtl/rarsf_dp.sv
// datapath: size register, both tree memories, walk position, accumulators and multipliers
// depends on rarsf_pkg
module rarsf_dp import rarsf_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_data,
	input  req_t              req,
	input  cmd_t              cmd,
	output stat_t             stat,
	output rsp_t              res
);

	localparam int unsigned DEPTH = MAX_POSITIONS + 1;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = ($clog2(DEPTH) + 1 > 12) ? $clog2(DEPTH) + 1 : 12;
	localparam int unsigned PROD_W = VALUE_W + POS_W + 1;

	logic [SUM_W-1:0] coeff_mem [DEPTH];
	logic [SUM_W-1:0] offset_mem [DEPTH];

	logic [SIZE_W-1:0] size_q;
	logic [AW-1:0] clr_q;

	logic kind_q;
	logic [POS_W-1:0] lo_q;
	logic [POS_W-1:0] hi_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [PW-1:0] n_q;
	logic [PW-1:0] pos_q;
	logic [SUM_W-1:0] off_lo_q;
	logic [SUM_W-1:0] off_hi_q;
	logic [SUM_W-1:0] csum_q;
	logic [SUM_W-1:0] osum_q;
	logic [SUM_W-1:0] prod_q;
	logic [SUM_W-1:0] pref_hi_q;
	logic [SUM_W-1:0] rd_c_q;
	logic [SUM_W-1:0] rd_o_q;
	rsp_t res_q;

	logic [POS_W-1:0] lom1;
	logic [POS_W-1:0] x;
	logic [PW-1:0] lowbit;
	logic [PW-1:0] size_ext;
	logic [SUM_W-1:0] v64;
	logic signed [PROD_W-1:0] p_lo;
	logic signed [PROD_W-1:0] p_hi;
	logic [AW-1:0] addr;
	logic we;
	logic [SUM_W-1:0] wd_c;
	logic [SUM_W-1:0] wd_o;

	assign lom1 = lo_q - POS_W'(1);
	assign x = cmd.walk ? lom1 : hi_q;
	assign lowbit = pos_q & (-pos_q);
	assign size_ext = PW'(size_q);
	assign v64 = {{(SUM_W-VALUE_W){value_q[VALUE_W-1]}}, value_q};
	assign p_lo = value_q * $signed({1'b0, lom1});
	assign p_hi = value_q * $signed({1'b0, hi_q});

	assign stat.clr_last = (clr_q == AW'(MAX_POSITIONS));
	assign stat.bad = (lo_q == '0) || (lo_q > hi_q) || (PW'(hi_q) > n_q);
	assign stat.query = (kind_q == KIND_QUERY);
	assign stat.walk_live = (pos_q != '0) && (pos_q <= n_q);

	assign addr = cmd.clr ? clr_q : pos_q[AW-1:0];
	assign we = cmd.clr | (cmd.upd & (kind_q == KIND_ADD));
	// second walk of an add carries the negated amounts
	assign wd_c = cmd.clr ? '0 : (cmd.walk ? rd_c_q - v64 : rd_c_q + v64);
	assign wd_o = cmd.clr ? '0 : (cmd.walk ? rd_o_q - off_hi_q : rd_o_q + off_lo_q);

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			coeff_mem[addr] <= wd_c;
			offset_mem[addr] <= wd_o;
		end
		rd_c_q <= coeff_mem[addr];
		rd_o_q <= offset_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			lo_q <= req.lo;
			hi_q <= req.hi;
			value_q <= req.value;
			n_q <= (size_ext > PW'(MAX_POSITIONS)) ? PW'(MAX_POSITIONS) : size_ext;
		end
		if (cmd.first) begin
			off_lo_q <= {{(SUM_W-PROD_W){p_lo[PROD_W-1]}}, p_lo};
			off_hi_q <= {{(SUM_W-PROD_W){p_hi[PROD_W-1]}}, p_hi};
			pos_q <= (kind_q == KIND_QUERY) ? PW'(hi_q) : PW'(lo_q);
			csum_q <= '0;
			osum_q <= '0;
			res_q.range_sum <= '0;
			res_q.bad_range <= stat.bad;
		end
		if (cmd.upd) begin
			if (kind_q == KIND_QUERY) begin
				csum_q <= csum_q + rd_c_q;
				osum_q <= osum_q + rd_o_q;
				pos_q <= pos_q - lowbit;
			end else begin
				pos_q <= pos_q + lowbit;
			end
		end
		if (cmd.second) begin
			pos_q <= (kind_q == KIND_QUERY) ? PW'(lom1) : PW'(hi_q) + PW'(1);
			csum_q <= '0;
			osum_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= csum_q * SUM_W'(x);
		end
		if (cmd.acc) begin
			if (!cmd.walk) begin
				pref_hi_q <= prod_q - osum_q;
			end else begin
				// prefix(hi) - (c*x - o)
				res_q.range_sum <= pref_hi_q - prod_q + osum_q;
			end
		end
	end

endmodule

// File: hw/rtl/rarsf_ctrl.sv
// controller: one-hot state machine sequencing clear pass, tree walks and result beat
// depends on rarsf_pkg
module rarsf_ctrl import rarsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_SETUP = 8'b0000_0100,
		ST_RD    = 8'b0000_1000,
		ST_UPD   = 8'b0001_0000,
		ST_MUL   = 8'b0010_0000,
		ST_ACC   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic second_q;
	logic second_d;

	always_comb begin
		cmd = '0;
		cmd.walk = second_q;
		state_d = state_q;
		second_d = second_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.first = 1'b1;
				second_d = 1'b0;
				state_d = stat.bad ? ST_DONE : ST_RD;
			end
			ST_RD: begin
				if (stat.walk_live) begin
					state_d = ST_UPD;
				end else if (stat.query) begin
					state_d = ST_MUL;
				end else if (!second_q) begin
					cmd.second = 1'b1;
					second_d = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_RD;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (!second_q) begin
					cmd.second = 1'b1;
					second_d = 1'b1;
					state_d = ST_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			second_q <= second_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_SETUP))
		else $error("accepted beat did not enter setup");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_upd_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $past(stat.walk_live))
		else $error("tree update outside the walk range");

	a_no_reclear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> (state_q != ST_CLEAR))
		else $error("clear pass restarted");

	a_bad_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP && stat.bad) |=> done)
		else $error("rejected range touched the trees");

endmodule

// File: sim/range_add_range_sum_fenwick_check.sv
// checker for the range-add / range-sum fenwick store: watches the item, result
// and size channels, predicts every result and compares it field by field
// depends on rarsf_pkg
`timescale 1ns / 1ps

module range_add_range_sum_fenwick_check import rarsf_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	input  logic              busy,
	input  logic              done,
	input  rsp_t              res,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	output int                errors,
	output int                pending
);

	logic [SUM_W-1:0] coeff_words [1:MAX_POSITIONS];
	logic [SUM_W-1:0] offset_words [1:MAX_POSITIONS];
	logic [SIZE_W-1:0] size_reg;
	rsp_t sum_expect_q [$];
	rsp_t want;

	function automatic void tree_bump(bit to_offset, int unsigned pos, int unsigned limit,
			logic [SUM_W-1:0] amount);
		while (pos >= 1 && pos <= limit) begin
			if (to_offset)
				offset_words[pos] += amount;
			else
				coeff_words[pos] += amount;
			pos += pos & (~pos + 1);
		end
	endfunction

	function automatic logic [SUM_W-1:0] tree_prefix(bit from_offset, int unsigned pos,
			int unsigned limit);
		logic [SUM_W-1:0] acc;
		acc = '0;
		if (pos > limit)
			pos = limit;
		while (pos > 0) begin
			acc += from_offset ? offset_words[pos] : coeff_words[pos];
			pos -= pos & (~pos + 1);
		end
		return acc;
	endfunction

	// prefix(x) = C(x) * x - O(x)
	function automatic logic [SUM_W-1:0] array_prefix(int unsigned x, int unsigned limit);
		logic [SUM_W-1:0] c_part;
		c_part = tree_prefix(1'b0, x, limit) * 64'(x);
		return c_part - tree_prefix(1'b1, x, limit);
	endfunction

	// applies an add to the trees or evaluates a query, returns the result beat; a rejected range only sets bad_range
	function automatic rsp_t predict_range_result(req_t r);
		rsp_t o;
		int unsigned lim, lo, hi;
		logic [SUM_W-1:0] v;
		o = '0;
		lim = (32'(size_reg) > MAX_POSITIONS) ? MAX_POSITIONS : 32'(size_reg);
		lo = 32'(r.lo);
		hi = 32'(r.hi);
		v = {{(SUM_W-VALUE_W){r.value[VALUE_W-1]}}, r.value};
		if (lo == 0 || lo > hi || hi > lim) begin
			o.bad_range = 1'b1;
			return o;
		end
		if (r.kind == KIND_ADD) begin
			tree_bump(1'b0, lo, lim, v);
			tree_bump(1'b0, hi + 1, lim, -v);
			tree_bump(1'b1, lo, lim, v * 64'(lo - 1));
			tree_bump(1'b1, hi + 1, lim, -(v * 64'(hi)));
		end else begin
			o.range_sum = array_prefix(hi, lim) - array_prefix(lo - 1, lim);
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= MAX_POSITIONS; i++) begin
				coeff_words[i] = '0;
				offset_words[i] = '0;
			end
			size_reg = SIZE_RESET;
			sum_expect_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (done) begin
				if (sum_expect_q.size() == 0) begin
					$error("result beat with no item outstanding: range_sum %0d bad_range %0b",
						res.range_sum, res.bad_range);
					errors++;
				end else begin
					want = sum_expect_q.pop_front();
					if (res.range_sum !== want.range_sum) begin
						$error("range_sum: expected %0d, got %0d", want.range_sum, res.range_sum);
						errors++;
					end
					if (res.bad_range !== want.bad_range) begin
						$error("bad_range: expected %0b, got %0b", want.bad_range, res.bad_range);
						errors++;
					end
				end
			end
			if (start && !busy)
				sum_expect_q.push_back(predict_range_result(req));
			pending <= sum_expect_q.size();
		end
	end

endmodule

// File: sim/range_add_range_sum_fenwick_test.sv
// testbench top for range_add_range_sum_fenwick: drives items and size writes,
// directed corners then random ranges over several sizes; verdict from the checker
// depends on rarsf_pkg, range_add_range_sum_fenwick, range_add_range_sum_fenwick_check
`timescale 1ns / 1ps

module range_add_range_sum_fenwick_test;
	import rarsf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic cfg_valid = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic cfg_ready;
	rsp_t res;
	int errors;
	int pending;
	int unsigned size_now = 32'(SIZE_RESET);
	bit idle_on = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	range_add_range_sum_fenwick dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	range_add_range_sum_fenwick_check sum_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	// one item, held until the block takes it
	task automatic issue(input logic kind, input int unsigned lo, input int unsigned hi,
			input logic [VALUE_W-1:0] value);
		req_t r;
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 19);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.kind = kind;
		r.lo = lo[POS_W-1:0];
		r.hi = hi[POS_W-1:0];
		r.value = value;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic write_size(input int unsigned v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v[SIZE_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_now = v;
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return 32'($urandom_range(0, 20)) - 32'd10;
			default: return $urandom;
		endcase
	endfunction

	// mostly legal ranges under the current size, some rejected ones
	task automatic random_item();
		int unsigned lim, lo, hi, room;
		logic kind;
		lim = (size_now > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : size_now;
		kind = 1'($urandom_range(0, 1));
		if (lim == 0 || $urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					lo = 0;
					hi = $urandom_range(0, 2047);
				end
				1: begin
					hi = $urandom_range(0, 2046);
					lo = $urandom_range(hi + 1, 2047);
				end
				default: begin
					hi = $urandom_range(lim + 1, 2047);
					lo = $urandom_range(0, hi);
				end
			endcase
		end else begin
			lo = $urandom_range(1, lim);
			room = lim - lo;
			if ($urandom_range(0, 3) == 0)
				hi = lo + $urandom_range(0, (room < 8) ? room : 8);
			else
				hi = $urandom_range(lo, lim);
		end
		issue(kind, lo, hi, random_value());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// full size after reset
		issue(KIND_QUERY, 1, 1024, 32'h0);
		issue(KIND_ADD, 1, 1024, 32'h7fff_ffff);
		issue(KIND_ADD, 1, 1, 32'h8000_0000);
		issue(KIND_ADD, 1024, 1024, 32'h1);
		issue(KIND_ADD, 1, 1024, 32'h0);
		issue(KIND_ADD, 300, 300, 32'hffff_ffff);
		issue(KIND_ADD, 2, 1023, $urandom);
		issue(KIND_QUERY, 1, 1024, 32'hffff_ffff);
		issue(KIND_QUERY, 1, 1, 32'h0);
		issue(KIND_QUERY, 1024, 1024, $urandom);
		issue(KIND_QUERY, 300, 300, 32'h0);
		issue(KIND_QUERY, 1, 512, 32'h0);
		issue(KIND_QUERY, 513, 1024, 32'h0);
		issue(KIND_ADD, 0, 5, 32'h5);
		issue(KIND_ADD, 10, 9, 32'h5);
		issue(KIND_ADD, 1, 1025, 32'h5);
		issue(KIND_QUERY, 2047, 2047, 32'h0);
		issue(KIND_QUERY, 0, 0, 32'h0);
		issue(KIND_QUERY, 1, 2047, 32'h0);
		issue(KIND_ADD, 1024, 1024, 32'h8000_0000);
		issue(KIND_QUERY, 1023, 1024, 32'h0);
		repeat (160) random_item();

		// smallest non-empty size
		write_size(1);
		issue(KIND_ADD, 1, 1, 32'h5);
		issue(KIND_QUERY, 1, 1, 32'h0);
		issue(KIND_ADD, 1, 2, 32'h5);
		repeat (40) random_item();

		// nothing in range
		write_size(0);
		issue(KIND_QUERY, 1, 1, 32'h0);
		issue(KIND_ADD, 0, 0, 32'h3);
		repeat (5) random_item();

		// above capacity, words from earlier sizes kept
		write_size(2047);
		issue(KIND_QUERY, 1, 1024, 32'h0);
		issue(KIND_ADD, 1024, 1024, 32'h7fff_ffff);
		issue(KIND_QUERY, 1, 1024, 32'h0);
		repeat (80) random_item();

		write_size(37);
		repeat (80) random_item();

		write_size(1024);
		repeat (70) random_item();

		// back to back to the end
		write_size(1000);
		idle_on = 1'b0;
		repeat (110) random_item();

		settle();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: range_add_range_sum_fenwick.f
hw/rtl/rarsf_pkg.sv
hw/rtl/rarsf_dp.sv
hw/rtl/rarsf_ctrl.sv
hw/rtl/range_add_range_sum_fenwick.sv
sim/range_add_range_sum_fenwick_check.sv
sim/range_add_range_sum_fenwick_test.sv
